>>> hdl/wsc_pkg.sv
`default_nettype none

package wsc_pkg;

	localparam int CELL_W     = 4;
	localparam int CFG_DATA_W = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int MIN_SIZE   = 3;
	localparam int RESET_SIZE = 64;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	localparam logic [CELL_W-1:0] AVG_MIN = 4'd1;
	localparam logic [CELL_W-1:0] AVG_MAX = 4'd9;

	// one window column: top, middle and bottom row
	typedef struct packed {
		logic [CELL_W-1:0] top;
		logic [CELL_W-1:0] mid;
		logic [CELL_W-1:0] bot;
	} col_t;

	// eight neighbors plus nine times the center, over 16, clamped
	function automatic logic [CELL_W-1:0] smooth_avg(col_t l, col_t m, col_t r);
		logic [7:0] sum;
		logic [CELL_W-1:0] avg;
		sum = 8'(l.top) + 8'(l.mid) + 8'(l.bot)
			+ 8'(m.top) + 8'(m.bot)
			+ 8'(r.top) + 8'(r.mid) + 8'(r.bot)
			+ {1'b0, m.mid, 3'b000} + {4'b0000, m.mid};
		avg = sum[7:4];
		if (avg < AVG_MIN) begin
			avg = AVG_MIN;
		end else if (avg > AVG_MAX) begin
			avg = AVG_MAX;
		end
		return avg;
	endfunction

endpackage

`default_nettype wire

>>> hdl/weighted_3x3_smoothing_clamp_core.sv
// Streaming 3x3 weighted smoothing filter. Cells arrive in raster order, one per clock
// unless stalled; every accepted transaction can be followed by another in the next cycle,
// the rate being set by the line memory, which does one read and one write per cycle. The
// result for a cell leaves with the transaction that comes frame_width+1 positions later,
// then passes through one output register; after the last cell of a frame send
// frame_width+1 flush transactions to drain it. Flush transactions sent before the last
// cell are dropped. Interior cells give (8 neighbors + 9 * center) / 16 clamped to 1..9,
// border cells pass through. frame_width and frame_height are saturated to 3..MAX_WIDTH /
// MAX_HEIGHT, and writing either one restarts the frame. in_stall follows out_stall while
// a result is held.
`default_nettype none

module weighted_3x3_smoothing_clamp_core #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_we,
	input  wire  [wsc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire  [wsc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  wire                               in_valid,
	output logic                              in_stall,
	input  wire  [wsc_pkg::CELL_W-1:0]        cell_value,
	input  wire                               flush,
	output logic                              out_valid,
	input  wire                               out_stall,
	output logic [wsc_pkg::CELL_W-1:0]        smoothed_value,
	output logic                              frame_last
);
	import wsc_pkg::*;

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int RW    = $clog2(MAX_HEIGHT + 2);
	localparam int W_RST = (MAX_WIDTH < RESET_SIZE) ? MAX_WIDTH : RESET_SIZE;
	localparam int H_RST = (MAX_HEIGHT < RESET_SIZE) ? MAX_HEIGHT : RESET_SIZE;

	logic [WW-1:0] w_q, w_new;
	logic [HW-1:0] h_q, h_new;
	logic [CW-1:0] in_column_q, col_d;
	logic [RW-1:0] in_row_q, row_d;
	logic          out_valid_q;
	logic [CELL_W-1:0] out_value_q;
	logic          out_last_q;

	logic cfg_w_hit, cfg_h_hit, restart;
	logic accept, draining, take, emit, border, last;
	logic [CELL_W-1:0] v, value;
	logic [WW-1:0] col_inc;
	logic [RW-1:0] h_ext;
	logic [2*CELL_W-1:0] rd_data, wr_data;
	col_t new_col, mid_col, left_col;

	assign cfg_w_hit = cfg_we && (cfg_index == REG_FRAME_WIDTH);
	assign cfg_h_hit = cfg_we && (cfg_index == REG_FRAME_HEIGHT);
	assign restart   = cfg_w_hit || cfg_h_hit;

	always_comb begin
		if (cfg_wdata < CFG_DATA_W'(MIN_SIZE)) begin
			w_new = WW'(MIN_SIZE);
		end else if (32'(cfg_wdata) > MAX_WIDTH) begin
			w_new = WW'(MAX_WIDTH);
		end else begin
			w_new = WW'(cfg_wdata);
		end
		if (cfg_wdata < CFG_DATA_W'(MIN_SIZE)) begin
			h_new = HW'(MIN_SIZE);
		end else if (32'(cfg_wdata) > MAX_HEIGHT) begin
			h_new = HW'(MAX_HEIGHT);
		end else begin
			h_new = HW'(cfg_wdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= WW'(W_RST);
			h_q <= HW'(H_RST);
		end else begin
			if (cfg_w_hit) begin
				w_q <= w_new;
			end
			if (cfg_h_hit) begin
				h_q <= h_new;
			end
		end
	end

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign h_ext    = RW'(h_q);
	assign draining = in_row_q >= h_ext;
	assign take     = accept && (draining || !flush) && !restart;
	assign v        = draining ? '0 : cell_value;

	assign new_col = '{top: rd_data[2*CELL_W-1:CELL_W], mid: rd_data[CELL_W-1:0], bot: v};
	assign wr_data = {rd_data[CELL_W-1:0], v};

	// positions of the cell whose result leaves now
	assign emit   = (in_row_q >= RW'(2)) || ((in_row_q == RW'(1)) && (in_column_q != '0));
	assign border = (in_column_q == '0) || (in_column_q == CW'(1))
		|| (in_row_q == RW'(1)) || (in_row_q == h_ext);
	assign last   = (in_column_q == '0) && (in_row_q == h_ext + RW'(1));
	assign value  = border ? mid_col.mid : smooth_avg(left_col, mid_col, new_col);
	assign col_inc = WW'(in_column_q) + WW'(1);

	always_comb begin
		col_d = in_column_q;
		row_d = in_row_q;
		if (restart) begin
			col_d = '0;
			row_d = '0;
		end else if (take) begin
			if (last) begin
				col_d = '0;
				row_d = '0;
			end else if (col_inc >= w_q) begin
				col_d = '0;
				row_d = in_row_q + RW'(1);
			end else begin
				col_d = CW'(col_inc);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_column_q <= '0;
			in_row_q    <= '0;
		end else begin
			in_column_q <= col_d;
			in_row_q    <= row_d;
		end
	end

	// upper and middle lines share one memory, same column address
	wsc_line_buffer #(
		.DEPTH  (MAX_WIDTH),
		.DATA_W (2 * CELL_W)
	) u_lines (
		.clk   (clk),
		.we    (take),
		.waddr (in_column_q),
		.wdata (wr_data),
		.raddr (col_d),
		.rdata (rd_data)
	);

	wsc_window_cell u_cell_right (
		.clk     (clk),
		.arst_n  (arst_n),
		.shift   (take),
		.clear   (restart),
		.col_in  (new_col),
		.col_out (mid_col)
	);

	wsc_window_cell u_cell_left (
		.clk     (clk),
		.arst_n  (arst_n),
		.shift   (take),
		.clear   (restart),
		.col_in  (mid_col),
		.col_out (left_col)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			out_value_q <= value;
			out_last_q  <= last;
		end
	end

	assign out_valid      = out_valid_q;
	assign smoothed_value = out_value_q;
	assign frame_last     = out_last_q;

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		WW'(in_column_q) < w_q)
		else $error("column counter beyond frame width");

	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		in_row_q <= h_ext + RW'(1))
		else $error("row counter beyond drain limit");

	a_last_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		take && last |=> (in_column_q == '0) && (in_row_q == '0))
		else $error("counters not cleared after last result");

	a_early_flush_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		accept && flush && !draining && !cfg_we |=> $stable(in_column_q) && $stable(in_row_q))
		else $error("flush before frame end moved the position");

	a_no_lost_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall && !cfg_we |=> out_valid_q && $stable(out_value_q))
		else $error("held result dropped or changed");

endmodule

`default_nettype wire

>>> hdl/wsc_window_cell.sv
`default_nettype none

module wsc_window_cell (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           shift,
	input  wire           clear,
	input  wire wsc_pkg::col_t col_in,
	output wsc_pkg::col_t col_out
);
	import wsc_pkg::*;

	col_t col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (clear) begin
			col_q <= '0;
		end else if (shift) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;

endmodule

`default_nettype wire

>>> hdl/wsc_line_buffer.sv
`default_nettype none

module wsc_line_buffer #(
	parameter int DEPTH  = 1024,
	parameter int DATA_W = 8
) (
	input  wire                       clk,
	input  wire                       we,
	input  wire  [$clog2(DEPTH)-1:0]  waddr,
	input  wire  [DATA_W-1:0]         wdata,
	input  wire  [$clog2(DEPTH)-1:0]  raddr,
	output logic [DATA_W-1:0]         rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire
